[design/hrd_pkg.sv]
// ----------------------------------------------------------------------------
// hrd_pkg: shared types and helpers for the hex record deframer
// Request and response payloads, parser phases, status codes, hex decode and
// the rotate step of the payload check.
// ----------------------------------------------------------------------------
package hrd_pkg;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic        start_of_record;
      logic        end_of_record;
      logic [15:0] expected_address;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  data_index;
      logic [15:0] record_address;
      logic [7:0]  record_length;
      logic [2:0]  status;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_OPEN,
      PH_ADDR,
      PH_SEP1,
      PH_LEN,
      PH_SEP2,
      PH_CHK,
      PH_SEP3,
      PH_DATA,
      PH_TERM,
      PH_DONE
   } phase_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SYNTAX    = 3'd1;
   localparam logic [2:0] ST_ADDRESS   = 3'd2;
   localparam logic [2:0] ST_CHECKSUM  = 3'd3;
   localparam logic [2:0] ST_NO_TERM   = 3'd4;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;

   localparam logic [2:0] ADDR_DIGITS = 3'd4;
   localparam logic [2:0] BYTE_DIGITS = 3'd2;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   // Decode one ASCII hex digit, either case
   function automatic hex_type hex_decode(input logic [7:0] ch);
      hex_type h;
      logic [7:0] d;
      h.ok    = 1'b1;
      h.value = 4'd0;
      d       = 8'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         d = ch - 8'h30;
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         d = ch - 8'h37;
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         d = ch - 8'h57;
      end else begin
         h.ok = 1'b0;
      end
      h.value = d[3:0];
      return h;
   endfunction

   // Low byte of a 16-bit right rotate of the zero-extended character
   function automatic logic [7:0] rot_low(input logic [7:0] ch, input logic [3:0] r);
      logic [31:0] w;
      w = {8'd0, ch, 8'd0, ch} >> r;
      return w[7:0];
   endfunction

endpackage

[design/hrd_in_stage.sv]
// ----------------------------------------------------------------------------
// hrd_in_stage: request input register
// Holds one request until the parser takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module hrd_in_stage (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  hrd_pkg::req_type req_data,
   input  logic            take,
   output logic            held_valid,
   output hrd_pkg::req_type held_data
);

   logic             valid_ff, valid_in;
   hrd_pkg::req_type data_ff;

   assign req_ready  = !valid_ff || take;
   assign held_valid = valid_ff;
   assign held_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

[design/hrd_parser.sv]
// ----------------------------------------------------------------------------
// hrd_parser: record parse state and per-character step
// Advances the header/payload state by one character and forms the result.
// ----------------------------------------------------------------------------
module hrd_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  hrd_pkg::req_type item,
   output logic             has_result,
   output hrd_pkg::rsp_type result
);

   hrd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  digit_ff, digit_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  chk_ff, chk_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  pos_ff, pos_in;
   logic [15:0] target_ff, target_in;

   hrd_pkg::phase_type cur_phase;
   hrd_pkg::hex_type   hex;
   logic [2:0]  digit_next;
   logic        have_data, have_verdict;
   logic [2:0]  status;
   logic [7:0]  idx;

   always_comb begin
      cur_phase  = phase_ff;
      digit_in   = digit_ff;
      addr_in    = addr_ff;
      len_in     = len_ff;
      chk_in     = chk_ff;
      sum_in     = sum_ff;
      pos_in     = pos_ff;
      target_in  = target_ff;
      have_data    = 1'b0;
      have_verdict = 1'b0;
      status     = hrd_pkg::ST_OK;
      idx        = 8'd0;
      hex        = hrd_pkg::hex_decode(item.rx_byte);

      // restart: drop any open record
      if (item.start_of_record) begin
         cur_phase = hrd_pkg::PH_OPEN;
         digit_in  = 3'd0;
         addr_in   = 16'd0;
         len_in    = 8'd0;
         chk_in    = 8'd0;
         sum_in    = 8'd0;
         pos_in    = 8'd0;
         target_in = item.expected_address;
      end
      phase_in   = cur_phase;
      digit_next = digit_in + 3'd1;

      case (cur_phase)
         hrd_pkg::PH_OPEN, hrd_pkg::PH_SEP1, hrd_pkg::PH_SEP2, hrd_pkg::PH_SEP3: begin
            if (item.rx_byte != hrd_pkg::CHAR_COLON) begin
               have_verdict = 1'b1;
               status       = hrd_pkg::ST_SYNTAX;
            end else begin
               digit_in = 3'd0;
               case (cur_phase)
                  hrd_pkg::PH_OPEN: phase_in = hrd_pkg::PH_ADDR;
                  hrd_pkg::PH_SEP1: phase_in = hrd_pkg::PH_LEN;
                  hrd_pkg::PH_SEP2: phase_in = hrd_pkg::PH_CHK;
                  default: begin
                     if (addr_in != target_in) begin
                        have_verdict = 1'b1;
                        status       = hrd_pkg::ST_ADDRESS;
                     end else if (len_in == 8'd0) begin
                        phase_in = hrd_pkg::PH_TERM;
                     end else begin
                        phase_in = hrd_pkg::PH_DATA;
                     end
                  end
               endcase
            end
         end
         hrd_pkg::PH_ADDR: begin
            if (!hex.ok) begin
               have_verdict = 1'b1;
               status       = hrd_pkg::ST_SYNTAX;
            end else begin
               addr_in  = {addr_in[11:0], hex.value};
               digit_in = digit_next;
               if (digit_next == hrd_pkg::ADDR_DIGITS) begin
                  phase_in = hrd_pkg::PH_SEP1;
               end
            end
         end
         hrd_pkg::PH_LEN, hrd_pkg::PH_CHK: begin
            if (!hex.ok) begin
               have_verdict = 1'b1;
               status       = hrd_pkg::ST_SYNTAX;
            end else begin
               if (cur_phase == hrd_pkg::PH_LEN) begin
                  len_in = {len_in[3:0], hex.value};
               end else begin
                  chk_in = {chk_in[3:0], hex.value};
               end
               digit_in = digit_next;
               if (digit_next == hrd_pkg::BYTE_DIGITS) begin
                  phase_in = (cur_phase == hrd_pkg::PH_LEN) ? hrd_pkg::PH_SEP2
                                                             : hrd_pkg::PH_SEP3;
               end
            end
         end
         hrd_pkg::PH_DATA: begin
            idx       = pos_in;
            sum_in    = sum_in + hrd_pkg::rot_low(item.rx_byte, pos_in[3:0]);
            pos_in    = pos_in + 8'd1;
            have_data = 1'b1;
            if (pos_in == len_in) begin
               phase_in = hrd_pkg::PH_TERM;
            end
         end
         hrd_pkg::PH_TERM: begin
            have_verdict = 1'b1;
            if (sum_in != chk_in) begin
               status = hrd_pkg::ST_CHECKSUM;
            end else if (item.rx_byte != hrd_pkg::CHAR_SEMI) begin
               status = hrd_pkg::ST_NO_TERM;
            end else begin
               status = hrd_pkg::ST_OK;
            end
         end
         default: begin
            phase_in = cur_phase;
         end
      endcase

      // truncated record: verdict replaces any data result
      if (cur_phase != hrd_pkg::PH_IDLE && cur_phase != hrd_pkg::PH_DONE &&
          item.end_of_record && !have_verdict) begin
         have_verdict = 1'b1;
         have_data    = 1'b0;
         status       = hrd_pkg::ST_SYNTAX;
      end

      if (have_verdict) begin
         phase_in = hrd_pkg::PH_DONE;
      end

      has_result            = have_data || have_verdict;
      result.kind           = have_verdict ? hrd_pkg::KIND_VERDICT : hrd_pkg::KIND_DATA;
      result.data_byte      = have_verdict ? 8'd0 : item.rx_byte;
      result.data_index     = have_verdict ? 8'd0 : idx;
      result.record_address = addr_in;
      result.record_length  = len_in;
      result.status         = have_verdict ? status : hrd_pkg::ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrd_pkg::PH_IDLE;
      end else if (take) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         digit_ff  <= digit_in;
         addr_ff   <= addr_in;
         len_ff    <= len_in;
         chk_ff    <= chk_in;
         sum_ff    <= sum_in;
         pos_ff    <= pos_in;
         target_ff <= target_in;
      end
   end

endmodule

[design/hex_record_deframer_rotsum_unit.sv]
// ----------------------------------------------------------------------------
// hex_record_deframer_rotsum_unit: hex record deframer with rotate-sum check
// Parses ':AAAA:LL:CC:' + LL payload characters + ';', passes the payload
// out and closes each record with one verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_data) carries one received
//   character per request, with start and end of record flags and the
//   address the record must carry (sampled on the start flag).
//   Response channel (rsp_valid/rsp_ready/rsp_data) carries data results
//   (kind 0: the payload character and its index) and one verdict per
//   record (kind 1: parsed address, length and a status code).
//   A request is held in an input register, parsed combinationally and its
//   response, if any, lands in the response register that drives rsp_valid.
//   Throughput is one request per cycle while the receiver does not stall; the
//   parse state is updated in the same cycle as the response register is loaded.
//   Characters that give no response (header digits, anything after the
//   verdict or outside a record) still wait for room in the response register.
//   When the receiver stalls, the response register holds; the input
//   register then fills and req_ready drops until rsp_ready returns.
//   Synchronous reset empties both registers and leaves the parser idle:
//   characters are ignored until a request with the start flag arrives.
// ----------------------------------------------------------------------------
module hex_record_deframer_rotsum_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hrd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hrd_pkg::rsp_type rsp_data
);

   logic             held_valid;
   hrd_pkg::req_type held_data;
   logic             take;
   logic             has_result;
   hrd_pkg::rsp_type result;

   logic             rsp_valid_ff, rsp_valid_in;
   hrd_pkg::rsp_type rsp_data_ff;

   // advance the held request once the response register has room
   assign take = held_valid && (!rsp_valid_ff || rsp_ready);

   hrd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (take),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   hrd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .item       (held_data),
      .has_result (has_result),
      .result     (result)
   );

   // response register: load on advance, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = has_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && has_result) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
